[design/rlcs_pkg.sv]
// Shared types and constants of the LED chain serializer.
// Pixel count, index types, byte slot codes, the offset reduction table and
// the structs passed between the sequencer and the bit timer. No dependencies.
`default_nettype none

package rlcs_pkg;

	// Number of pixels in the chain and the width of a pixel index.
	localparam int PIXELS = 64;
	localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	typedef logic [AW-1:0] pix_idx_t;

	// Byte slots of the shift word, in the order they are loaded.
	localparam logic [1:0] SLOT_NONE  = 2'd0;
	localparam logic [1:0] SLOT_GREEN = 2'd1;
	localparam logic [1:0] SLOT_RED   = 2'd2;
	localparam logic [1:0] SLOT_BLUE  = 2'd3;

	// Reduction of an 8-bit rotation offset into the pixel range.
	typedef pix_idx_t mod_tbl_t [256];

	function automatic mod_tbl_t build_mod_tbl();
		mod_tbl_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = AW'(i % PIXELS);
		end
		return t;
	endfunction

	localparam mod_tbl_t MOD_TBL = build_mod_tbl();

	// Bit timing registers.
	typedef struct packed {
		logic [9:0] zero_high;
		logic [9:0] zero_period;
		logic [9:0] one_high;
		logic [9:0] one_period;
	} timing_t;

	// Sequencer to bit timer controls.
	typedef struct packed {
		logic       tick;
		logic       restart;
		logic       ld_en;
		logic [1:0] ld_sel;
		logic [7:0] ld_byte;
	} tmr_ctrl_t;

	// Bit timer status for the current tick.
	typedef struct packed {
		logic line;
		logic bit_done;
		logic word_done;
	} tmr_stat_t;

	// One result item.
	typedef struct packed {
		logic line;
		logic busy;
		logic fend;
		logic rej;
	} res_t;

endpackage

`default_nettype wire

[design/rgb_led_chain_serializer_core.sv]
// LED chain serializer. Requests arrive on the input channel (in_valid,
// in_stall) and each yields one result on the output channel (out_valid,
// out_stall). Configuration is a write port: cfg_we, cfg_addr, cfg_wdata.
// Every request's result is decided in the cycle it is taken and is registered
// onto the output, or parked while the output is stalled. A tick, a write that
// changes no pixel or a rejected request needs no further work. A single pixel
// write then writes the memory. A start, and a tick that finishes any pixel but
// the last, then run a pixel load (three reads of the single memory port, each
// scaled by the shared 8x8 multiplier). A single component write then reads,
// merges and writes; broadcast writes repeat this for every pixel in turn
// through the one write port of the pixel memory, with in_stall high meanwhile.
// Reset clears all pixels at once, stops any frame and restores the register
// defaults. A result that the receiver stalls is held; one further request is
// taken and its result parked, after which in_stall stays high until the
// output drains.
`default_nettype none

module rgb_led_chain_serializer_core
	import rlcs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [9:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic        all_pixels,
	input  wire logic [7:0]  index,
	input  wire logic [1:0]  channel,
	input  wire logic [23:0] value,
	input  wire logic [7:0]  red_offset,
	input  wire logic [7:0]  green_offset,
	input  wire logic [7:0]  blue_offset,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             line_level,
	output logic             busy_res,
	output logic             frame_end,
	output logic             rejected
);

	localparam logic [1:0] OP_PIXEL = 2'd0;
	localparam logic [1:0] OP_COMP  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [1:0] CH_BLUE  = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_RED   = 2'd2;
	localparam logic [1:0] CH_INTEN = 2'd3;

	localparam logic [2:0] REG_ZERO_HIGH = 3'd0;
	localparam logic [2:0] REG_ZERO_PER  = 3'd1;
	localparam logic [2:0] REG_ONE_HIGH  = 3'd2;
	localparam logic [2:0] REG_ONE_PER   = 3'd3;
	localparam logic [2:0] REG_BR_EN     = 3'd4;
	localparam logic [2:0] REG_BR_VAL    = 3'd5;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PWR  = 3'd1;
	localparam logic [2:0] ST_CRD  = 3'd2;
	localparam logic [2:0] ST_CWR  = 3'd3;
	localparam logic [2:0] ST_LOAD = 3'd4;

	localparam pix_idx_t LAST_PIX = AW'(PIXELS - 1);

	// Configuration registers.
	timing_t    timing_q;
	logic       br_en_q;
	logic [7:0] br_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.zero_high   <= 10'd4;
			timing_q.zero_period <= 10'd12;
			timing_q.one_high    <= 10'd8;
			timing_q.one_period  <= 10'd12;
			br_en_q              <= 1'b0;
			br_val_q             <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ZERO_HIGH: timing_q.zero_high   <= cfg_wdata;
				REG_ZERO_PER:  timing_q.zero_period <= cfg_wdata;
				REG_ONE_HIGH:  timing_q.one_high    <= cfg_wdata;
				REG_ONE_PER:   timing_q.one_period  <= cfg_wdata;
				REG_BR_EN:     br_en_q              <= cfg_wdata[0];
				REG_BR_VAL:    br_val_q             <= cfg_wdata[7:0];
				default:       ;
			endcase
		end
	end

	// Sequencer state.
	logic [2:0]  state_q;
	logic        sending_q;
	pix_idx_t    pix_q;
	pix_idx_t    sweep_q;
	logic        all_q;
	logic [1:0]  chan_q;
	logic [23:0] val_q;
	logic [1:0]  ld_step_q;
	pix_idx_t    ofs_r_q;
	pix_idx_t    ofs_g_q;
	pix_idx_t    ofs_b_q;

	// Output register and one parked result.
	res_t res;
	res_t out_q;
	res_t pend_res_q;
	logic out_valid_q;
	logic pend_q;

	logic acc;
	logic out_free;
	logic is_write;
	logic in_range;
	logic tick_run;

	tmr_ctrl_t tctrl;
	tmr_stat_t tstat;

	logic        mem_we;
	pix_idx_t    mem_wa;
	logic [23:0] mem_wd;
	pix_idx_t    mem_ra;
	logic [23:0] mem_rd;

	pix_idx_t    ld_ofs;
	logic [AW:0] src_sum;
	pix_idx_t    src;
	logic [7:0]  src_byte;
	logic [7:0]  sf;
	logic [15:0] prod;
	logic [23:0] merged;

	assign in_stall = (state_q != ST_IDLE) || pend_q;
	assign acc      = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign is_write = (op == OP_PIXEL) || (op == OP_COMP);
	assign in_range = ({1'b0, index} < 9'(PIXELS));
	assign tick_run = acc && (op == OP_TICK) && sending_q;

	// Result of the request being taken.
	always_comb begin
		res.line = tick_run && tstat.line;
		res.rej  = acc && sending_q && (op != OP_TICK);
		res.fend = tick_run && tstat.word_done && (pix_q == LAST_PIX);
		if (acc && (op == OP_START) && !sending_q) begin
			res.busy = 1'b1;
		end else begin
			res.busy = sending_q && !res.fend;
		end
	end

	// Source pixel of the byte read in this step of a pixel load.
	always_comb begin
		case (ld_step_q)
			2'd0:    ld_ofs = ofs_g_q;
			2'd1:    ld_ofs = ofs_r_q;
			default: ld_ofs = ofs_b_q;
		endcase
		src_sum = {1'b0, pix_q} + {1'b0, ld_ofs};
		if (src_sum >= (AW + 1)'(PIXELS)) begin
			src = AW'(src_sum - (AW + 1)'(PIXELS));
		end else begin
			src = src_sum[AW-1:0];
		end
	end

	// Shared scaling multiplier on the byte read one step earlier.
	always_comb begin
		case (ld_step_q)
			2'd1:    src_byte = mem_rd[15:8];
			2'd2:    src_byte = mem_rd[23:16];
			default: src_byte = mem_rd[7:0];
		endcase
		sf   = br_en_q ? br_val_q : 8'hFF;
		prod = {8'd0, src_byte} * {8'd0, sf};
	end

	// Component merge for read-modify-write.
	always_comb begin
		merged = mem_rd;
		case (chan_q)
			CH_BLUE:  merged[7:0]   = val_q[7:0];
			CH_GREEN: merged[15:8]  = val_q[7:0];
			CH_RED:   merged[23:16] = val_q[7:0];
			default:  ;
		endcase
	end

	// Memory port selection.
	always_comb begin
		mem_we = (state_q == ST_PWR) || (state_q == ST_CWR);
		mem_wa = sweep_q;
		mem_wd = (state_q == ST_PWR) ? val_q : merged;
		mem_ra = (state_q == ST_LOAD) ? src : sweep_q;
	end

	// Bit timer controls.
	always_comb begin
		tctrl.tick    = tick_run;
		tctrl.restart = acc && (op == OP_START) && !sending_q;
		tctrl.ld_en   = (state_q == ST_LOAD) && (ld_step_q != 2'd0);
		case (ld_step_q)
			2'd1:    tctrl.ld_sel = SLOT_GREEN;
			2'd2:    tctrl.ld_sel = SLOT_RED;
			2'd3:    tctrl.ld_sel = SLOT_BLUE;
			default: tctrl.ld_sel = SLOT_NONE;
		endcase
		tctrl.ld_byte = prod[15:8];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sending_q <= 1'b0;
			pix_q     <= '0;
			ld_step_q <= '0;
			ofs_r_q   <= '0;
			ofs_g_q   <= '0;
			ofs_b_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc && !sending_q && is_write) begin
						if (all_pixels || in_range) begin
							if (op == OP_PIXEL) begin
								state_q <= ST_PWR;
							end else if (channel != CH_INTEN) begin
								state_q <= ST_CRD;
							end
						end
					end else if (acc && !sending_q && (op == OP_START)) begin
						ofs_r_q   <= MOD_TBL[red_offset];
						ofs_g_q   <= MOD_TBL[green_offset];
						ofs_b_q   <= MOD_TBL[blue_offset];
						sending_q <= 1'b1;
						pix_q     <= '0;
						ld_step_q <= '0;
						state_q   <= ST_LOAD;
					end else if (tick_run && tstat.word_done) begin
						if (pix_q == LAST_PIX) begin
							sending_q <= 1'b0;
							pix_q     <= '0;
						end else begin
							pix_q     <= pix_q + AW'(1);
							ld_step_q <= '0;
							state_q   <= ST_LOAD;
						end
					end
				end
				ST_PWR: begin
					if (!all_q || (sweep_q == LAST_PIX)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CRD: begin
					state_q <= ST_CWR;
				end
				ST_CWR: begin
					state_q <= (!all_q || (sweep_q == LAST_PIX)) ? ST_IDLE : ST_CRD;
				end
				ST_LOAD: begin
					ld_step_q <= ld_step_q + 2'd1;
					if (ld_step_q == 2'd3) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Write request fields and the sweep address.
	always_ff @(posedge clk) begin
		if (acc && is_write) begin
			all_q   <= all_pixels;
			chan_q  <= channel;
			val_q   <= value;
			sweep_q <= all_pixels ? '0 : index[AW-1:0];
		end else if ((state_q == ST_PWR) || (state_q == ST_CWR)) begin
			sweep_q <= sweep_q + AW'(1);
		end
	end

	// Output register with a parked result behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (pend_q) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end
		end else if (acc) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				pend_q <= 1'b1;
			end
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			if (out_free) begin
				out_q <= pend_res_q;
			end
		end else if (acc) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				pend_res_q <= res;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign line_level = out_q.line;
	assign busy_res   = out_q.busy;
	assign frame_end  = out_q.fend;
	assign rejected   = out_q.rej;

	rlcs_pixel_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_we),
		.wr_addr (mem_wa),
		.wr_data (mem_wd),
		.rd_addr (mem_ra),
		.rd_data (mem_rd)
	);

	rlcs_bit_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.timing (timing_q),
		.ctrl   (tctrl),
		.stat   (tstat)
	);

endmodule

`default_nettype wire

[design/rlcs_pixel_mem.sv]
// Pixel store: one write port, one registered read port, per-entry valid bits.
// An entry never written since reset reads as zero. Depends on rlcs_pkg.
`default_nettype none

module rlcs_pixel_mem
	import rlcs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire pix_idx_t    wr_addr,
	input  wire logic [23:0] wr_data,
	input  wire pix_idx_t    rd_addr,
	output logic [23:0]      rd_data
);

	logic [23:0]       mem [PIXELS];
	logic [PIXELS-1:0] valid_q;
	logic [23:0]       rd_q;
	logic              rd_valid_q;

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Valid bits make the reset clear immediate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_q : 24'd0;

endmodule

`default_nettype wire

[design/rlcs_bit_timer.sv]
// Bit timer: shift word, tick and bit counters, and the line level decision.
// Depends on rlcs_pkg for the timing and control structs.
`default_nettype none

module rlcs_bit_timer
	import rlcs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire timing_t   timing,
	input  wire tmr_ctrl_t ctrl,
	output tmr_stat_t      stat
);

	logic [23:0] shift_q;
	logic [9:0]  tick_q;
	logic [4:0]  bit_q;

	logic        cur_one;
	logic [9:0]  high;
	logic [9:0]  per_raw;
	logic [9:0]  period;
	logic [10:0] tick_nx;

	// Timing of the bit at the head of the shift word. A period of zero
	// still ends the bit after one tick, which the compare below covers.
	always_comb begin
		cur_one  = shift_q[23];
		high     = cur_one ? timing.one_high : timing.zero_high;
		per_raw  = cur_one ? timing.one_period : timing.zero_period;
		period   = (per_raw < high) ? high : per_raw;
		tick_nx  = {1'b0, tick_q} + 11'd1;
		stat.line      = (tick_q < high);
		stat.bit_done  = (tick_nx >= {1'b0, period});
		stat.word_done = stat.bit_done && (bit_q == 5'd23);
	end

	// Counters and shift word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			tick_q  <= '0;
			bit_q   <= '0;
		end else begin
			if (ctrl.restart) begin
				tick_q <= '0;
				bit_q  <= '0;
			end else if (ctrl.tick) begin
				if (stat.bit_done) begin
					tick_q  <= '0;
					shift_q <= {shift_q[22:0], 1'b0};
					bit_q   <= stat.word_done ? 5'd0 : bit_q + 5'd1;
				end else begin
					tick_q <= tick_nx[9:0];
				end
			end
			if (ctrl.ld_en) begin
				case (ctrl.ld_sel)
					SLOT_GREEN: shift_q[23:16] <= ctrl.ld_byte;
					SLOT_RED:   shift_q[15:8]  <= ctrl.ld_byte;
					SLOT_BLUE:  shift_q[7:0]   <= ctrl.ld_byte;
					default:    ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

[tb/tb_rgb_led_chain_serializer_core.sv]
// Self-checking testbench of the LED chain serializer core: directed and random
// requests, a predictor of the pixel store and serial line, and per-field checks.
// Depends on rlcs_pkg and rgb_led_chain_serializer_core.
module tb_rgb_led_chain_serializer_core;
	import rlcs_pkg::*;

	typedef enum logic [1:0] {OP_PIXEL_WR, OP_COMP_WR, OP_START, OP_TICK} led_op_t;

	localparam logic [1:0] CH_BLUE      = 2'd0;
	localparam logic [1:0] CH_GREEN     = 2'd1;
	localparam logic [1:0] CH_RED       = 2'd2;
	localparam logic [1:0] CH_INTENSITY = 2'd3;

	localparam logic [2:0] REG_ZERO_HIGH   = 3'd0;
	localparam logic [2:0] REG_ZERO_PERIOD = 3'd1;
	localparam logic [2:0] REG_ONE_HIGH    = 3'd2;
	localparam logic [2:0] REG_ONE_PERIOD  = 3'd3;
	localparam logic [2:0] REG_BRIGHT_EN   = 3'd4;
	localparam logic [2:0] REG_BRIGHTNESS  = 3'd5;

	// Broadcast component writes keep the pixel memory busy with a read and a write per pixel.
	localparam int SETTLE_CYCLES = 2 * PIXELS + 16;
	localparam int DRAIN_LIMIT   = 100000;

	typedef struct packed {
		led_op_t     opc;
		logic        bcast;
		logic [7:0]  idx;
		logic [1:0]  chn;
		logic [23:0] val;
		logic [7:0]  r_off;
		logic [7:0]  g_off;
		logic [7:0]  b_off;
	} led_req_t;

	// Block ports.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [9:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = '0;
	logic        all_pixels = 1'b0;
	logic [7:0]  index = '0;
	logic [1:0]  channel = '0;
	logic [23:0] value = '0;
	logic [7:0]  red_offset = '0;
	logic [7:0]  green_offset = '0;
	logic [7:0]  blue_offset = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        line_level;
	logic        busy_res;
	logic        frame_end;
	logic        rejected;

	// Predicted chain state and register copies.
	logic [23:0] m_store [PIXELS];
	logic        m_sending = 1'b0;
	int unsigned m_pix = 0;
	int unsigned m_bit = 0;
	int unsigned m_tick = 0;
	logic [23:0] m_shift = '0;
	int unsigned m_off_r = 0;
	int unsigned m_off_g = 0;
	int unsigned m_off_b = 0;
	int unsigned m_zero_hi = 4;
	int unsigned m_zero_per = 12;
	int unsigned m_one_hi = 8;
	int unsigned m_one_per = 12;
	logic        m_bri_en = 1'b0;
	logic [7:0]  m_bri = 8'hFF;

	led_req_t request_q [$];
	res_t     status_exp_q [$];
	led_req_t cur_req;
	res_t     got_status;
	res_t     want_status;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       err_cnt = 0;
	int       frames_done = 0;

	rgb_led_chain_serializer_core DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Scale one color byte by the active brightness factor.
	function automatic logic [7:0] scale_color(input logic [7:0] c);
		logic [15:0] prod;
		prod = c * (m_bri_en ? m_bri : 8'hFF);
		return prod[15:8];
	endfunction

	// Gather green, red and blue of one output pixel from the rotated sources.
	function automatic void load_word(input int unsigned i);
		logic [7:0] g, r, b;
		g = scale_color(m_store[(i + m_off_g) % PIXELS][15:8]);
		r = scale_color(m_store[(i + m_off_r) % PIXELS][23:16]);
		b = scale_color(m_store[(i + m_off_b) % PIXELS][7:0]);
		m_shift = {g, r, b};
	endfunction

	function automatic void store_write(input int unsigned i, input led_req_t r);
		if (r.opc == OP_PIXEL_WR) begin
			m_store[i] = r.val;
		end else begin
			case (r.chn)
				CH_BLUE: m_store[i][7:0] = r.val[7:0];
				CH_GREEN: m_store[i][15:8] = r.val[7:0];
				CH_RED: m_store[i][23:16] = r.val[7:0];
				default: ;
			endcase
		end
	endfunction

	// Apply one accepted request to the predicted state and return its status.
	function automatic res_t advance_chain(input led_req_t r);
		res_t o;
		int unsigned hi, per;
		o = '0;
		case (r.opc)
			OP_PIXEL_WR, OP_COMP_WR: begin
				if (m_sending) begin
					o.rej = 1'b1;
				end else if (r.bcast) begin
					for (int i = 0; i < PIXELS; i++) store_write(i, r);
				end else if (r.idx < PIXELS) begin
					store_write(r.idx, r);
				end
			end
			OP_START: begin
				if (m_sending) begin
					o.rej = 1'b1;
				end else begin
					m_off_r = r.r_off % PIXELS;
					m_off_g = r.g_off % PIXELS;
					m_off_b = r.b_off % PIXELS;
					m_sending = 1'b1;
					m_pix = 0;
					m_bit = 0;
					m_tick = 0;
					load_word(0);
				end
			end
			default: begin
				if (m_sending) begin
					hi = m_shift[23] ? m_one_hi : m_zero_hi;
					per = m_shift[23] ? m_one_per : m_zero_per;
					if (per < hi) per = hi;
					if (per == 0) per = 1;
					o.line = (m_tick < hi);
					m_tick++;
					if (m_tick >= per) begin
						m_tick = 0;
						m_shift = m_shift << 1;
						m_bit++;
						if (m_bit >= 24) begin
							m_bit = 0;
							if (m_pix + 1 >= PIXELS) begin
								m_sending = 1'b0;
								m_pix = 0;
								o.fend = 1'b1;
								frames_done++;
							end else begin
								m_pix++;
								load_word(m_pix);
							end
						end
					end
				end
			end
		endcase
		o.busy = m_sending;
		return o;
	endfunction

	function automatic led_req_t mk_req(input led_op_t o, input logic b, input logic [7:0] i,
			input logic [1:0] c, input logic [23:0] v);
		led_req_t r;
		r.opc = o;
		r.bcast = b;
		r.idx = i;
		r.chn = c;
		r.val = v;
		r.r_off = 8'($urandom);
		r.g_off = 8'($urandom);
		r.b_off = 8'($urandom);
		return r;
	endfunction

	// Random content; most single writes land inside the chain, a few are broadcasts.
	function automatic led_req_t random_req(input led_op_t o);
		logic [7:0] i;
		i = ($urandom_range(99) < 80) ? 8'($urandom_range(PIXELS - 1)) : 8'($urandom_range(255));
		return mk_req(o, $urandom_range(99) < 6, i, 2'($urandom), 24'($urandom));
	endfunction

	// Driver: present queued requests, hold each one until it is accepted.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			status_exp_q.push_back(advance_chain(cur_req));
		end
		if (!in_valid || !in_stall) begin
			if (arst_n && request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_req = request_q.pop_front();
				in_valid <= 1'b1;
				op <= cur_req.opc;
				all_pixels <= cur_req.bcast;
				index <= cur_req.idx;
				channel <= cur_req.chn;
				value <= cur_req.val;
				red_offset <= cur_req.r_off;
				green_offset <= cur_req.g_off;
				blue_offset <= cur_req.b_off;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each accepted result with the oldest expected status.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_status = {line_level, busy_res, frame_end, rejected};
			if (status_exp_q.size() == 0) begin
				$error("result with no request outstanding: %b", got_status);
				err_cnt++;
			end else begin
				want_status = status_exp_q.pop_front();
				if (got_status.line !== want_status.line) begin
					$error("line_level: expected %0b, got %0b", want_status.line, got_status.line);
					err_cnt++;
				end
				if (got_status.busy !== want_status.busy) begin
					$error("busy_res: expected %0b, got %0b", want_status.busy, got_status.busy);
					err_cnt++;
				end
				if (got_status.fend !== want_status.fend) begin
					$error("frame_end: expected %0b, got %0b", want_status.fend, got_status.fend);
					err_cnt++;
				end
				if (got_status.rej !== want_status.rej) begin
					$error("rejected: expected %0b, got %0b", want_status.rej, got_status.rej);
					err_cnt++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic write_register(input logic [2:0] addr, input logic [9:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			REG_ZERO_HIGH: m_zero_hi = data;
			REG_ZERO_PERIOD: m_zero_per = data;
			REG_ONE_HIGH: m_one_hi = data;
			REG_ONE_PERIOD: m_one_per = data;
			REG_BRIGHT_EN: m_bri_en = data[0];
			REG_BRIGHTNESS: m_bri = data[7:0];
			default: ;
		endcase
	endtask

	// Wait until every queued request has been accepted.
	task automatic wait_drained();
		while (request_q.size() != 0 || in_valid) @(posedge clk);
	endtask

	// Wait for all results, then let background memory work finish.
	task automatic settle();
		wait_drained();
		while (status_exp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Counts of zero or one make every bit last a single tick, so a frame takes
	// one tick per bit while the line still follows the high counts.
	task automatic randomize_timing();
		write_register(REG_ZERO_HIGH, 10'($urandom_range(1)));
		write_register(REG_ZERO_PERIOD, 10'($urandom_range(1)));
		write_register(REG_ONE_HIGH, 10'($urandom_range(1)));
		write_register(REG_ONE_PERIOD, 10'($urandom_range(1)));
	endtask

	task automatic randomize_brightness();
		int pick;
		pick = $urandom_range(99);
		write_register(REG_BRIGHT_EN, 10'($urandom_range(1)));
		if (pick < 15) write_register(REG_BRIGHTNESS, 10'd0);
		else if (pick < 30) write_register(REG_BRIGHTNESS, 10'd255);
		else write_register(REG_BRIGHTNESS, 10'($urandom_range(255)));
	endtask

	initial begin : stimulus
		led_req_t rq;
		int seg, k, pick, issued, waited;
		bit long_done;
		issued = 0;
		long_done = 1'b0;
		for (int i = 0; i < PIXELS; i++) m_store[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Zero bits of zero length, one bits with a period below the high count.
		write_register(REG_ZERO_HIGH, 10'd0);
		write_register(REG_ZERO_PERIOD, 10'd0);
		write_register(REG_ONE_HIGH, 10'd1);
		write_register(REG_ONE_PERIOD, 10'd0);
		write_register(REG_BRIGHT_EN, 10'd1);
		write_register(REG_BRIGHTNESS, 10'd128);

		// Directed requests: chain ends, ignored indexes, every channel, busy rejects.
		request_q.push_back(mk_req(OP_TICK, 1'b0, 8'd0, CH_BLUE, 24'h000000));
		request_q.push_back(mk_req(OP_PIXEL_WR, 1'b1, 8'd0, CH_BLUE, 24'hFFFFFF));
		request_q.push_back(mk_req(OP_PIXEL_WR, 1'b0, 8'd0, CH_BLUE, 24'h000000));
		request_q.push_back(mk_req(OP_PIXEL_WR, 1'b0, 8'(PIXELS - 1), CH_RED, 24'hA5C3F0));
		request_q.push_back(mk_req(OP_PIXEL_WR, 1'b0, 8'(PIXELS), CH_RED, 24'h123456));
		request_q.push_back(mk_req(OP_PIXEL_WR, 1'b0, 8'hFF, CH_RED, 24'h000000));
		request_q.push_back(mk_req(OP_COMP_WR, 1'b0, 8'd1, CH_BLUE, 24'hFFFF00));
		request_q.push_back(mk_req(OP_COMP_WR, 1'b0, 8'd2, CH_GREEN, 24'h000081));
		request_q.push_back(mk_req(OP_COMP_WR, 1'b0, 8'd3, CH_RED, 24'h00007E));
		request_q.push_back(mk_req(OP_COMP_WR, 1'b0, 8'd4, CH_INTENSITY, 24'h000000));
		request_q.push_back(mk_req(OP_COMP_WR, 1'b0, 8'hC8, CH_RED, 24'h000000));
		request_q.push_back(mk_req(OP_COMP_WR, 1'b1, 8'd0, CH_GREEN, 24'h00003C));
		request_q.push_back(mk_req(OP_COMP_WR, 1'b1, 8'd0, CH_INTENSITY, 24'hFFFFFF));
		// Random pixel content for the frame that follows.
		for (k = 0; k < 40; k++) begin
			if ($urandom_range(1) == 0) request_q.push_back(random_req(OP_PIXEL_WR));
			else request_q.push_back(random_req(OP_COMP_WR));
		end
		rq = mk_req(OP_START, 1'b0, 8'd0, CH_BLUE, 24'h000000);
		rq.r_off = 8'hFF;
		rq.g_off = 8'h00;
		rq.b_off = 8'(PIXELS);
		request_q.push_back(rq);
		request_q.push_back(mk_req(OP_PIXEL_WR, 1'b0, 8'd5, CH_BLUE, 24'h777777));
		request_q.push_back(mk_req(OP_COMP_WR, 1'b1, 8'd0, CH_RED, 24'h0000AA));
		request_q.push_back(mk_req(OP_START, 1'b0, 8'd0, CH_BLUE, 24'h000000));
		for (k = 0; k < 6; k++) request_q.push_back(mk_req(OP_TICK, 1'b0, 8'd0, CH_BLUE, 24'h0));
		wait_drained();

		// Random part: tick the frame through while busy, fill and start while idle.
		seg = 0;
		while (frames_done < 1 || issued < 1350 || !long_done) begin
			case (seg % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 65; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 65; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			if (m_sending && !long_done && seg >= 8) begin
				// Maximum counts mid-frame, then wider bits whose period is cut
				// below the ticks already spent, then back to short bits.
				settle();
				write_register(REG_ZERO_HIGH, 10'd1023);
				write_register(REG_ZERO_PERIOD, 10'd0);
				write_register(REG_ONE_HIGH, 10'd0);
				write_register(REG_ONE_PERIOD, 10'd1023);
				for (k = 0; k < 60; k++) begin
					request_q.push_back(random_req(OP_TICK));
				end
				settle();
				write_register(REG_ZERO_HIGH, 10'd3);
				write_register(REG_ZERO_PERIOD, 10'd5);
				write_register(REG_ONE_HIGH, 10'd5);
				write_register(REG_ONE_PERIOD, 10'd2);
				for (k = 0; k < 60; k++) begin
					request_q.push_back(random_req(OP_TICK));
				end
				issued += 120;
				settle();
				randomize_timing();
				long_done = 1'b1;
			end else if (m_sending) begin
				// Timing and brightness may change while the frame runs.
				if ($urandom_range(2) == 0) begin
					settle();
					randomize_timing();
					randomize_brightness();
				end
				for (k = 0; k < 120; k++) begin
					if ($urandom_range(99) < 92) request_q.push_back(random_req(OP_TICK));
					else request_q.push_back(random_req(led_op_t'(2'($urandom_range(2)))));
				end
				issued += 120;
			end else begin
				settle();
				randomize_timing();
				randomize_brightness();
				for (k = 0; k < 30; k++) begin
					pick = $urandom_range(99);
					if (pick < 42) begin
						request_q.push_back(random_req(OP_PIXEL_WR));
					end else if (pick < 84) begin
						request_q.push_back(random_req(OP_COMP_WR));
					end else begin
						request_q.push_back(random_req(OP_TICK));
					end
				end
				request_q.push_back(random_req(OP_START));
				issued += 31;
			end
			wait_drained();
			seg++;
		end

		// Drain the remaining results, then allow for trailing activity.
		waited = 0;
		while (status_exp_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (status_exp_q.size() != 0) begin
			$error("%0d expected results never arrived", status_exp_q.size());
			err_cnt++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
